>>> hdl/fftm_pkg.sv
`timescale 1ns / 1ps
package fftm_pkg;

    localparam int MAX_POINTS_DEF = 1024;
    localparam logic [3:0] LOG2_RST = 4'd10;
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_READ = 1'b1;
    localparam logic [16:0] MAG_SAT = 17'd65536;
    localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

    typedef struct packed {
        logic              mode;
        logic signed [15:0] sample;
        logic [8:0]        bin_index;
    } item_t;

    typedef struct packed {
        logic [8:0]  bin_number;
        logic [16:0] magnitude;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FFT,
        ST_DRAIN,
        ST_MAG_RD,
        ST_MAG_CALC,
        ST_MAG_OUT
    } state_t;

    function automatic logic [63:0] tw_term(input logic [63:0] t, input logic [63:0] x);
        return (((t * x) >> 30) * x) >> 30;
    endfunction

    function automatic logic signed [63:0] q30_to_q15(input logic signed [63:0] v);
        logic signed [63:0] w;
        w = (v < 0) ? 64'sd0 : v;
        return (w + 64'sd16384) >>> 15;
    endfunction

    function automatic logic signed [63:0] clamp16(input logic signed [63:0] v);
        if (v > 64'sd32767) return 64'sd32767;
        if (v < -64'sd32768) return -64'sd32768;
        return v;
    endfunction

    // twiddle j of a table for 2^lg points: {cos, -sin} in Q1.15
    function automatic logic [31:0] tw_entry(input int unsigned j, input int unsigned lg);
        logic [63:0] m;
        logic [63:0] half;
        logic [63:0] quarter;
        logic [63:0] jj;
        logic [63:0] x;
        logic [63:0] ts;
        logic [63:0] tc;
        logic signed [63:0] s;
        logic signed [63:0] c;
        logic signed [63:0] cq;
        logic signed [63:0] sq;
        logic signed [63:0] re;
        logic signed [63:0] im;
        logic mirror;
        m = 64'd1 << lg;
        half = m >> 1;
        quarter = m >> 2;
        mirror = 64'(j) > quarter;
        jj = mirror ? half - 64'(j) : 64'(j);
        x = (TWO_PI_Q30 * jj + half) >> lg;
        ts = x;
        tc = 64'd1 << 30;
        s = $signed(x);
        c = $signed(tc);
        ts = tw_term(ts, x) / 64'd6;   tc = tw_term(tc, x) / 64'd2;
        s = s - $signed(ts);           c = c - $signed(tc);
        ts = tw_term(ts, x) / 64'd20;  tc = tw_term(tc, x) / 64'd12;
        s = s + $signed(ts);           c = c + $signed(tc);
        ts = tw_term(ts, x) / 64'd42;  tc = tw_term(tc, x) / 64'd30;
        s = s - $signed(ts);           c = c - $signed(tc);
        ts = tw_term(ts, x) / 64'd72;  tc = tw_term(tc, x) / 64'd56;
        s = s + $signed(ts);           c = c + $signed(tc);
        ts = tw_term(ts, x) / 64'd110; tc = tw_term(tc, x) / 64'd90;
        s = s - $signed(ts);           c = c - $signed(tc);
        ts = tw_term(ts, x) / 64'd156; tc = tw_term(tc, x) / 64'd132;
        s = s + $signed(ts);           c = c + $signed(tc);
        ts = tw_term(ts, x) / 64'd210; tc = tw_term(tc, x) / 64'd182;
        s = s - $signed(ts);           c = c - $signed(tc);
        ts = tw_term(ts, x) / 64'd272; tc = tw_term(tc, x) / 64'd240;
        s = s + $signed(ts);           c = c + $signed(tc);
        ts = tw_term(ts, x) / 64'd342; tc = tw_term(tc, x) / 64'd306;
        s = s - $signed(ts);           c = c - $signed(tc);
        ts = tw_term(ts, x) / 64'd420; tc = tw_term(tc, x) / 64'd380;
        s = s + $signed(ts);           c = c + $signed(tc);
        cq = q30_to_q15(c);
        sq = q30_to_q15(s);
        re = clamp16(mirror ? -cq : cq);
        im = clamp16(-sq);
        return {re[15:0], im[15:0]};
    endfunction

endpackage

>>> hdl/fftm_store.sv
`timescale 1ns / 1ps
module fftm_store #(
    parameter int AW = 10,
    parameter int DW = 52
) (
    input  logic          clk,
    input  logic [AW-1:0] ra0,
    input  logic [AW-1:0] ra1,
    output logic [DW-1:0] rd0,
    output logic [DW-1:0] rd1,
    input  logic          we,
    input  logic [AW-1:0] wa,
    input  logic [DW-1:0] wd
);

    logic [DW-1:0] store_mem [2**AW];
    logic [DW-1:0] rd0_reg;
    logic [DW-1:0] rd1_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_mem[wa] <= wd;
        end
        rd0_reg <= store_mem[ra0];
        rd1_reg <= store_mem[ra1];
    end

    assign rd0 = rd0_reg;
    assign rd1 = rd1_reg;

endmodule

>>> hdl/fftm_bfly.sv
`timescale 1ns / 1ps
module fftm_bfly
    import fftm_pkg::*;
#(
    parameter int LOG2_MAX = 10,
    parameter int VW = 26
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   issue,
    input  logic [LOG2_MAX-1:0]                    addr_a,
    input  logic [LOG2_MAX-1:0]                    addr_b,
    input  logic [((LOG2_MAX > 1) ? LOG2_MAX-1 : 1)-1:0] tw_idx,
    input  logic [2*VW-1:0]                        rd_a,
    input  logic [2*VW-1:0]                        rd_b,
    output logic                                   wr_en,
    output logic [LOG2_MAX-1:0]                    wr_addr,
    output logic [2*VW-1:0]                        wr_data,
    output logic                                   busy
);

    localparam int AW = LOG2_MAX;
    localparam int TW_DEPTH = (2**LOG2_MAX) / 2;
    localparam int PW = 16 + VW;
    localparam logic signed [VW+2:0] VMAX = (VW+3)'((64'sd1 <<< (VW-1)) - 64'sd1);
    localparam logic signed [VW+2:0] VMIN = (VW+3)'(-(64'sd1 <<< (VW-1)));

    logic [31:0] tw_rom [TW_DEPTH];

    for (genvar g = 0; g < TW_DEPTH; g++)
    begin : g_rom
        assign tw_rom[g] = tw_entry(g, LOG2_MAX);
    end

    function automatic logic [VW-1:0] sat_val(input logic signed [VW+2:0] v);
        if (v > VMAX) return VMAX[VW-1:0];
        if (v < VMIN) return VMIN[VW-1:0];
        return v[VW-1:0];
    endfunction

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic [31:0] tw_reg;
    logic [AW-1:0] a1_reg, b1_reg, a2_reg, b2_reg, a3_reg, b3_reg, a4_reg, b4_reg;
    logic signed [PW-1:0] prr_reg, pii_reg, pri_reg, pir_reg;
    logic [2*VW-1:0] ea2_reg, ea3_reg;
    logic signed [VW+1:0] tr_reg, ti_reg;
    logic [2*VW-1:0] ra_reg, rb_reg;

    logic signed [15:0] wr, wi;
    logic signed [VW-1:0] br, bi, ar, ai;
    logic signed [PW:0] dre, dim;
    logic signed [VW+2:0] sre, sim, dfre, dfim;

    always_comb
    begin
        wr = $signed(tw_reg[31:16]);
        wi = $signed(tw_reg[15:0]);
        br = $signed(rd_b[2*VW-1:VW]);
        bi = $signed(rd_b[VW-1:0]);
        ar = $signed(ea3_reg[2*VW-1:VW]);
        ai = $signed(ea3_reg[VW-1:0]);
        dre = (PW+1)'(prr_reg) - (PW+1)'(pii_reg) + (PW+1)'(16384);
        dim = (PW+1)'(pri_reg) + (PW+1)'(pir_reg) + (PW+1)'(16384);
        sre = (VW+3)'(ar) + (VW+3)'(tr_reg);
        sim = (VW+3)'(ai) + (VW+3)'(ti_reg);
        dfre = (VW+3)'(ar) - (VW+3)'(tr_reg);
        dfim = (VW+3)'(ai) - (VW+3)'(ti_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            tw_reg <= tw_rom[tw_idx];
            a1_reg <= addr_a;
            b1_reg <= addr_b;
        end
        if (v1_reg)
        begin
            prr_reg <= PW'(wr * br);
            pii_reg <= PW'(wi * bi);
            pri_reg <= PW'(wr * bi);
            pir_reg <= PW'(wi * br);
            ea2_reg <= rd_a;
            a2_reg <= a1_reg;
            b2_reg <= b1_reg;
        end
        if (v2_reg)
        begin
            tr_reg <= dre[PW:15];
            ti_reg <= dim[PW:15];
            ea3_reg <= ea2_reg;
            a3_reg <= a2_reg;
            b3_reg <= b2_reg;
        end
        if (v3_reg)
        begin
            ra_reg <= {sat_val(sre), sat_val(sim)};
            rb_reg <= {sat_val(dfre), sat_val(dfim)};
            a4_reg <= a3_reg;
            b4_reg <= b3_reg;
        end
    end

    // even half goes back first, odd half in the cycle after
    assign wr_en = v4_reg | v5_reg;
    assign wr_addr = v4_reg ? a4_reg : b4_reg;
    assign wr_data = v4_reg ? ra_reg : rb_reg;
    assign busy = v1_reg | v2_reg | v3_reg | v4_reg | v5_reg;

endmodule

>>> hdl/fftm_mag.sv
`timescale 1ns / 1ps
module fftm_mag
    import fftm_pkg::*;
#(
    parameter int VW = 26
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic            force_zero,
    input  logic [3:0]      l_eff,
    input  logic [2*VW-1:0] rdata,
    output logic            done,
    output logic [16:0]     magnitude
);

    localparam int XW = 2 * VW + 2;
    localparam int STEPS = VW + 1;
    localparam int CW = $clog2(STEPS + 1);

    logic sq_v_reg, run_reg, fin_reg, done_reg, zero_reg;
    logic [CW-1:0] cnt_reg;
    logic [2*VW-1:0] re_sq_reg, im_sq_reg;
    logic [XW-1:0] rem_reg, root_reg, bit_reg;
    logic [16:0] mag_reg;

    logic signed [VW-1:0] re, im;
    logic [2*VW-1:0] sq_sum;
    logic [XW-1:0] trial, rem_next, root_next, rnd, shv;

    always_comb
    begin
        re = $signed(rdata[2*VW-1:VW]);
        im = $signed(rdata[VW-1:0]);
        sq_sum = re_sq_reg + im_sq_reg;
        trial = root_reg + bit_reg;
        if (rem_reg >= trial)
        begin
            rem_next = rem_reg - trial;
            root_next = (root_reg >> 1) + bit_reg;
        end
        else
        begin
            rem_next = rem_reg;
            root_next = root_reg >> 1;
        end
        rnd = root_reg + (XW'(1) << (l_eff - 4'd1));
        shv = rnd >> l_eff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_v_reg <= 1'b0;
            run_reg <= 1'b0;
            fin_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            sq_v_reg <= start;
            fin_reg <= 1'b0;
            done_reg <= fin_reg;
            if (sq_v_reg)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(STEPS - 1))
                begin
                    run_reg <= 1'b0;
                    fin_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            re_sq_reg <= (2*VW)'(re * re);
            im_sq_reg <= (2*VW)'(im * im);
            zero_reg <= force_zero;
        end
        if (sq_v_reg)
        begin
            rem_reg <= {sq_sum, 2'b00};
            root_reg <= '0;
            bit_reg <= XW'(1) << (XW - 2);
        end
        else if (run_reg)
        begin
            rem_reg <= rem_next;
            root_reg <= root_next;
            bit_reg <= bit_reg >> 2;
        end
        if (fin_reg)
        begin
            if (zero_reg)
            begin
                mag_reg <= '0;
            end
            else if (shv > XW'(MAG_SAT))
            begin
                mag_reg <= MAG_SAT;
            end
            else
            begin
                mag_reg <= shv[16:0];
            end
        end
    end

    assign done = done_reg;
    assign magnitude = mag_reg;

endmodule

>>> hdl/fft_magnitude_spectrum_unit.sv
`timescale 1ns / 1ps
// Load beat: accepted while idle; the N-th load starts an in-place transform of
// log2N stages, each issuing its butterflies in turn (each writes two results on the
// single store write port), then draining the butterfly pipeline.
// Read beat: magnitude from an iterative square root.
// Reset: asynchronous, active low; control clears, size returns to 1024 points,
// store contents stay undefined until loaded.
module fft_magnitude_spectrum_unit
    import fftm_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    input  item_t      item,
    output logic       result_valid,
    input  logic       result_ready,
    output result_t    result,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [3:0] cfg_data
);

    localparam int LOG2_MAX = $clog2(MAX_POINTS);
    localparam int AW = LOG2_MAX;
    localparam int VW = 16 + LOG2_MAX;
    localparam int DW = 2 * VW;
    localparam int TWA = (LOG2_MAX > 1) ? LOG2_MAX - 1 : 1;

    state_t state_reg, state_next;
    logic [3:0] log2_reg;
    logic [AW-1:0] load_cnt_reg;
    logic spec_rdy_reg;
    logic [3:0] stage_reg;
    logic [AW-1:0] j_reg;
    logic phase_reg;
    logic [8:0] bin_reg;
    logic zero_reg;
    logic out_valid_reg;
    result_t out_data_reg;

    logic [3:0] l_eff;
    logic [AW-1:0] n_last, half_last, rev, pos, half_s, k, addr_a, addr_b;
    logic [15:0] half_n;
    logic [TWA-1:0] tw_idx;
    logic accept, load_acc, read_acc, cfg_acc;
    logic issue, last_issue, mag_start, out_load, fft_done, stage_adv;
    logic [AW-1:0] ra0, wa;
    logic [DW-1:0] rd0, rd1, wd;
    logic we;
    logic bf_we, bf_busy;
    logic [AW-1:0] bf_wa;
    logic [DW-1:0] bf_wd;
    logic mag_done;
    logic [16:0] mag_val;
    logic signed [VW-1:0] ld_re;

    always_comb
    begin
        if (log2_reg == 4'd0)
        begin
            l_eff = 4'd1;
        end
        else if (log2_reg > 4'(LOG2_MAX))
        begin
            l_eff = 4'(LOG2_MAX);
        end
        else
        begin
            l_eff = log2_reg;
        end
        n_last = AW'(((AW+1)'(1) << l_eff) - (AW+1)'(1));
        half_n = 16'd1 << (l_eff - 4'd1);
        half_last = AW'(half_n - 16'd1);
        for (int i = 0; i < AW; i++)
        begin
            rev[i] = load_cnt_reg[AW-1-i];
        end
        pos = rev >> (4'(AW) - l_eff);
        half_s = AW'(1) << (stage_reg - 4'd1);
        k = j_reg & (half_s - AW'(1));
        addr_a = ((j_reg >> (stage_reg - 4'd1)) << stage_reg) | k;
        addr_b = addr_a | half_s;
        tw_idx = TWA'(k << (4'(LOG2_MAX) - stage_reg));
    end

    assign item_ready = (state_reg == ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign accept = item_valid & item_ready;
    assign load_acc = accept & (item.mode == MODE_LOAD);
    assign read_acc = accept & (item.mode == MODE_READ);
    assign cfg_acc = cfg_valid & cfg_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (load_acc && load_cnt_reg == n_last)
                begin
                    state_next = ST_FFT;
                end
                else if (read_acc)
                begin
                    state_next = ST_MAG_RD;
                end
            end
            ST_FFT:
            begin
                if (last_issue)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!bf_busy)
                begin
                    state_next = (stage_reg == l_eff) ? ST_IDLE : ST_FFT;
                end
            end
            ST_MAG_RD:
            begin
                state_next = ST_MAG_CALC;
            end
            ST_MAG_CALC:
            begin
                if (mag_done)
                begin
                    state_next = ST_MAG_OUT;
                end
            end
            ST_MAG_OUT:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        issue = (state_reg == ST_FFT) && !phase_reg;
        last_issue = issue && (j_reg == half_last);
        mag_start = (state_reg == ST_MAG_RD);
        out_load = (state_reg == ST_MAG_OUT) && (!out_valid_reg || result_ready);
        fft_done = (state_reg == ST_DRAIN) && !bf_busy && (stage_reg == l_eff);
        stage_adv = (state_reg == ST_DRAIN) && !bf_busy && (stage_reg != l_eff);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            log2_reg <= LOG2_RST;
            load_cnt_reg <= '0;
            spec_rdy_reg <= 1'b0;
            stage_reg <= 4'd1;
            j_reg <= '0;
            phase_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_acc)
            begin
                log2_reg <= cfg_data;
                load_cnt_reg <= '0;
                spec_rdy_reg <= 1'b0;
            end
            else if (load_acc)
            begin
                spec_rdy_reg <= 1'b0;
                load_cnt_reg <= (load_cnt_reg == n_last) ? '0 : load_cnt_reg + AW'(1);
            end
            else if (fft_done)
            begin
                spec_rdy_reg <= 1'b1;
            end
            if (load_acc)
            begin
                stage_reg <= 4'd1;
                j_reg <= '0;
                phase_reg <= 1'b0;
            end
            else if (issue)
            begin
                j_reg <= j_reg + AW'(1);
                phase_reg <= 1'b1;
            end
            else if (state_reg == ST_FFT)
            begin
                phase_reg <= 1'b0;
            end
            else if (stage_adv)
            begin
                stage_reg <= stage_reg + 4'd1;
                j_reg <= '0;
                phase_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (read_acc)
        begin
            bin_reg <= item.bin_index;
            zero_reg <= !spec_rdy_reg || (16'(item.bin_index) >= half_n);
        end
        if (out_load)
        begin
            out_data_reg.bin_number <= bin_reg;
            out_data_reg.magnitude <= mag_val;
        end
    end

    // store port arbitration: loads only in idle, butterflies only in transform
    always_comb
    begin
        ld_re = VW'(item.sample);
        ra0 = (state_reg == ST_FFT) ? addr_a : AW'(item.bin_index);
        we = load_acc | bf_we;
        wa = load_acc ? pos : bf_wa;
        wd = load_acc ? {ld_re, {VW{1'b0}}} : bf_wd;
    end

    fftm_store #(
        .AW (AW),
        .DW (DW)
    ) u_store (
        .clk (clk),
        .ra0 (ra0),
        .ra1 (addr_b),
        .rd0 (rd0),
        .rd1 (rd1),
        .we  (we),
        .wa  (wa),
        .wd  (wd)
    );

    fftm_bfly #(
        .LOG2_MAX (LOG2_MAX),
        .VW       (VW)
    ) u_bfly (
        .clk     (clk),
        .rst_n   (rst_n),
        .issue   (issue),
        .addr_a  (addr_a),
        .addr_b  (addr_b),
        .tw_idx  (tw_idx),
        .rd_a    (rd0),
        .rd_b    (rd1),
        .wr_en   (bf_we),
        .wr_addr (bf_wa),
        .wr_data (bf_wd),
        .busy    (bf_busy)
    );

    fftm_mag #(
        .VW (VW)
    ) u_mag (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (mag_start),
        .force_zero (zero_reg),
        .l_eff      (l_eff),
        .rdata      (rd0),
        .done       (mag_done),
        .magnitude  (mag_val)
    );

    assign result_valid = out_valid_reg;
    assign result = out_data_reg;

endmodule

>>> sim/fft_magnitude_spectrum_unit_test.sv
`timescale 1ns / 1ps
module fft_magnitude_spectrum_unit_test;
    import fftm_pkg::*;

    localparam int LIMIT = 3000000;
    localparam longint STORE_MAX = (64'sd1 <<< 25) - 1;
    localparam longint STORE_MIN = -(64'sd1 <<< 25);

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_ready;
    item_t item = '0;
    logic result_valid;
    logic result_ready = 1'b0;
    result_t result;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [3:0] cfg_data = '0;

    longint twiddle_cos [512];
    longint twiddle_sin [512];
    longint spec_re [1024];
    longint spec_im [1024];
    logic [3:0] size_reg;
    int frame_fill;
    bit spectrum_valid;
    result_t pending_bins [$];
    int errors = 0;
    int cycles = 0;
    int items_sent = 0;
    bit quiet = 0;
    bit gaps_on = 1;
    int stall_left = 0;

    fft_magnitude_spectrum_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_ready(item_ready), .item(item),
        .result_valid(result_valid), .result_ready(result_ready), .result(result),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            result_ready <= 1'b0;
        end
        else if (!quiet && gaps_on && $urandom_range(0, 11) == 0)
        begin
            stall_left = $urandom_range(1, 9) - 1;
            result_ready <= 1'b0;
        end
        else
            result_ready <= 1'b1;
    end

    function automatic longint sat16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint to_q15(longint v);
        if (v < 0) v = 0;
        return (v + 16384) >>> 15;
    endfunction

    function automatic void build_twiddles();
        bit [63:0] x, ts, tc, jj;
        longint s, c, cq, sq;
        bit mirror;
        for (int j = 0; j < 512; j++)
        begin
            mirror = j > 256;
            jj = mirror ? 512 - j : j;
            x = (64'd6746518852 * jj + 64'd512) / 64'd1024;
            ts = x;
            tc = 64'd1 << 30;
            s = x;
            c = tc;
            for (int n = 1; n <= 10; n++)
            begin
                ts = (((ts * x) >> 30) * x >> 30) / ((2 * n) * (2 * n + 1));
                tc = (((tc * x) >> 30) * x >> 30) / ((2 * n - 1) * (2 * n));
                if (n % 2) begin s -= ts; c -= tc; end
                else begin s += ts; c += tc; end
            end
            cq = to_q15(c);
            sq = to_q15(s);
            twiddle_cos[j] = sat16(mirror ? -cq : cq);
            twiddle_sin[j] = sat16(-sq);
        end
    endfunction

    function automatic int active_log2();
        if (size_reg == 0) return 1;
        if (size_reg > 10) return 10;
        return size_reg;
    endfunction

    function automatic longint clip_store(longint v);
        if (v > STORE_MAX) return STORE_MAX;
        if (v < STORE_MIN) return STORE_MIN;
        return v;
    endfunction

    function automatic void transform(int lg);
        int n, half, step, a, b, w;
        longint tr, ti, er, ei;
        n = 1 << lg;
        for (int len = 2; len <= n; len <<= 1)
        begin
            half = len >> 1;
            step = 1024 / len;
            for (int base = 0; base < n; base += len)
                for (int k = 0; k < half; k++)
                begin
                    a = base + k;
                    b = a + half;
                    w = k * step;
                    tr = (twiddle_cos[w] * spec_re[b] - twiddle_sin[w] * spec_im[b] + 16384)
                         >>> 15;
                    ti = (twiddle_cos[w] * spec_im[b] + twiddle_sin[w] * spec_re[b] + 16384)
                         >>> 15;
                    er = spec_re[a];
                    ei = spec_im[a];
                    spec_re[a] = clip_store(er + tr);
                    spec_im[a] = clip_store(ei + ti);
                    spec_re[b] = clip_store(er - tr);
                    spec_im[b] = clip_store(ei - ti);
                end
        end
    endfunction

    function automatic bit [63:0] int_sqrt(bit [63:0] x);
        bit [63:0] r, bt;
        r = 0;
        bt = 64'd1 << 62;
        while (bt > x) bt >>= 2;
        while (bt != 0)
        begin
            if (x >= r + bt)
            begin
                x -= r + bt;
                r = (r >> 1) + bt;
            end
            else
                r >>= 1;
            bt >>= 2;
        end
        return r;
    endfunction

    function automatic void predict_beat(item_t it);
        int lg, n, pos, cnt;
        bit [63:0] mag, ar, ai;
        result_t exp_r;
        lg = active_log2();
        n = 1 << lg;
        if (it.mode == MODE_LOAD)
        begin
            cnt = frame_fill & (n - 1);
            pos = 0;
            for (int i = 0; i < lg; i++)
            begin
                pos = (pos << 1) | (cnt & 1);
                cnt >>= 1;
            end
            spec_re[pos] = it.sample;
            spec_im[pos] = 0;
            spectrum_valid = 0;
            frame_fill++;
            if (frame_fill >= n)
            begin
                transform(lg);
                spectrum_valid = 1;
                frame_fill = 0;
            end
            return;
        end
        mag = 0;
        if (spectrum_valid && it.bin_index < (n >> 1))
        begin
            ar = spec_re[it.bin_index] < 0 ? -spec_re[it.bin_index] : spec_re[it.bin_index];
            ai = spec_im[it.bin_index] < 0 ? -spec_im[it.bin_index] : spec_im[it.bin_index];
            mag = (int_sqrt((ar * ar + ai * ai) * 4) + (64'd1 << (lg - 1))) >> lg;
            if (mag > MAG_SAT) mag = MAG_SAT;
        end
        exp_r.bin_number = it.bin_index;
        exp_r.magnitude = mag[16:0];
        pending_bins.push_back(exp_r);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_bins.size() == 0)
                report_mismatch("unexpected beat, bin", int'(result.bin_number), -1);
            else
            begin
                want = pending_bins.pop_front();
                if (result.bin_number !== want.bin_number)
                    report_mismatch("bin_number", int'(result.bin_number),
                                    int'(want.bin_number));
                if (result.magnitude !== want.magnitude)
                    report_mismatch("magnitude", int'(result.magnitude),
                                    int'(want.magnitude));
            end
        end
    end

    task automatic send_beat(logic m, logic [15:0] s, logic [8:0] b);
        item_t it;
        it.mode = m;
        it.sample = s;
        it.bin_index = b;
        if (!quiet && gaps_on && $urandom_range(0, 7) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        do @(posedge clk); while (!item_ready);
        predict_beat(it);
        items_sent++;
    endtask

    task automatic settle();
        int lg;
        item_valid <= 1'b0;
        while (pending_bins.size() != 0) @(posedge clk);
        lg = active_log2();
        repeat (lg * ((1 << lg) + 5) + 200) @(posedge clk);
    endtask

    task automatic write_size(logic [3:0] v);
        settle();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        size_reg = v;
        frame_fill = 0;
        spectrum_valid = 0;
    endtask

    task automatic load_frame(int n, int kind);
        logic [15:0] s;
        for (int i = 0; i < n; i++)
        begin
            case (kind)
                1: s = 16'h7fff;
                2: s = 16'h8000;
                3: s = (i % 2) ? 16'h8000 : 16'h7fff;
                default: s = 16'($urandom());
            endcase
            send_beat(MODE_LOAD, s, 9'($urandom()));
        end
    endtask

    task automatic read_bins(int count, int n);
        logic [8:0] b;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 3) != 0) b = 9'($urandom_range(0, n / 2 - 1));
            else b = 9'($urandom());
            send_beat(MODE_READ, 16'($urandom()), b);
        end
    endtask

    task automatic test_reset_reads();
        send_beat(MODE_READ, 16'h7fff, 9'd0);
        send_beat(MODE_READ, 16'h8000, 9'd511);
    endtask

    task automatic test_small_extremes();
        write_size(4'd0);
        send_beat(MODE_LOAD, 16'h7fff, 9'd511);
        send_beat(MODE_LOAD, 16'h8000, 9'd0);
        send_beat(MODE_READ, 16'h8000, 9'd0);
        send_beat(MODE_READ, 16'h0, 9'd1);
        send_beat(MODE_READ, 16'h0, 9'd511);
        write_size(4'd3);
        load_frame(8, 1);
        send_beat(MODE_READ, 16'hffff, 9'd0);
        send_beat(MODE_READ, 16'h0, 9'd3);
        send_beat(MODE_LOAD, 16'h1234, 9'd0);
        send_beat(MODE_READ, 16'h0, 9'd0);
    endtask

    task automatic test_oversize();
        write_size(4'd15);
        send_beat(MODE_READ, 16'h0, 9'd1);
        send_beat(MODE_LOAD, 16'h8000, 9'd5);
        send_beat(MODE_READ, 16'h0, 9'd2);
        write_size(4'd11);
        send_beat(MODE_READ, 16'h0, 9'd0);
    endtask

    task automatic test_full_size();
        write_size(4'd10);
        load_frame(1024, 0);
        read_bins(30, 1024);
    endtask

    task automatic test_random_frames();
        int lg, n, r;
        while (items_sent < 1650)
        begin
            if (items_sent > 1350) quiet = 1;
            gaps_on = $urandom_range(0, 3) != 0;
            r = $urandom_range(0, 9);
            if (r == 0)
                write_size(4'($urandom_range(11, 15)));
            else if (r < 8 || frame_fill != 0)
                write_size(4'($urandom_range(0, 6)));
            lg = active_log2();
            n = 1 << lg;
            if (lg == 10)
            begin
                read_bins(4, 2);
                send_beat(MODE_LOAD, 16'($urandom()), 9'd0);
                read_bins(2, 2);
                continue;
            end
            if ($urandom_range(0, 5) == 0)
            begin
                load_frame(n / 2, 0);
                read_bins(2, n);
            end
            load_frame(n - (n / 2) * (frame_fill != 0), $urandom_range(0, 6));
            read_bins($urandom_range(2, 10), n);
        end
    endtask

    initial
    begin
        build_twiddles();
        size_reg = LOG2_RST;
        frame_fill = 0;
        spectrum_valid = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_reads();
        test_small_extremes();
        test_oversize();
        test_full_size();
        test_random_frames();
        quiet = 1;
        settle();
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
